// ----- src/ffcd_pkg.sv -----
// Shared types and constants of the fixed-frame checksum deframer.
package ffcd_pkg;

	localparam int unsigned MAX_PAYLOAD_LEN = 128;

	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
	localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
	localparam logic [1:0] REG_PAYLOAD_LEN = 2'd2;
	localparam logic [1:0] REG_BAD_LIMIT   = 2'd3;

	localparam logic [7:0] RST_SYNC_FIRST  = 8'd170;
	localparam logic [7:0] RST_SYNC_SECOND = 8'd85;
	localparam logic [7:0] RST_PAYLOAD_LEN = 8'd64;
	localparam logic [7:0] RST_BAD_LIMIT   = 8'd50;

	localparam logic [7:0]  RUN_MAX   = 8'hFF;
	localparam logic [31:0] TOTAL_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [7:0] sync_first;
		logic [7:0] sync_second;
		logic [7:0] eff_len;
		logic [7:0] bad_limit;
	} cfg_t;

endpackage

// ----- src/ffcd_rx_if.sv -----
// Received byte channel.
interface ffcd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- src/ffcd_res_if.sv -----
// Result channel: payload pass-through, frame status and counters.
interface ffcd_res_if;
	logic        valid;
	logic        ready;
	logic        payload_valid;
	logic [7:0]  payload_byte;
	logic [6:0]  payload_index;
	logic        frame_done;
	logic        frame_good;
	logic        record_enable;
	logic [7:0]  bad_run_count;
	logic [31:0] good_frames;
	logic [31:0] bad_frames;

	modport source (
		output valid, output payload_valid, output payload_byte, output payload_index,
		output frame_done, output frame_good, output record_enable,
		output bad_run_count, output good_frames, output bad_frames,
		input ready
	);
	modport sink (
		input valid, input payload_valid, input payload_byte, input payload_index,
		input frame_done, input frame_good, input record_enable,
		input bad_run_count, input good_frames, input bad_frames,
		output ready
	);
endinterface

// ----- src/fixed_frame_checksum_deframer_core.sv -----
// Top level of the fixed-frame checksum deframer.
// Takes one received byte per transfer and returns one result per byte, one byte per
// clock cycle sustained while results are taken. A byte lands in an input register, the
// frame logic (header match, payload sum, checksum compare, saturating counters) runs
// in a single pass and fills the result register, from which the result is offered;
// both registers advance together, so a stalled result only holds up new bytes once the
// input register is full. Write configuration only while no byte is in flight; the
// counters shown with each result are the values after that byte.
module fixed_frame_checksum_deframer_core (
	input  logic                        clk,
	input  logic                        arst_n,
	ffcd_rx_if.sink                     rx,
	ffcd_res_if.source                  result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ffcd_pkg::ADDR_W-1:0] paddr,
	input  logic [ffcd_pkg::DATA_W-1:0] pwdata,
	output logic [ffcd_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);

	ffcd_pkg::cfg_t cfg;

	assign pready = 1'b1;

	ffcd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	ffcd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.rx     (rx),
		.result (result)
	);

endmodule

// ----- src/ffcd_regs.sv -----
// Configuration register bank behind the APB-style port.
module ffcd_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ffcd_pkg::ADDR_W-1:0] paddr,
	input  logic [ffcd_pkg::DATA_W-1:0] pwdata,
	output logic [ffcd_pkg::DATA_W-1:0] prdata,
	output ffcd_pkg::cfg_t              cfg
);

	logic [7:0] sync_first_q;
	logic [7:0] sync_second_q;
	logic [7:0] payload_len_q;
	logic [7:0] bad_limit_q;
	logic [1:0] reg_idx;
	logic       wr_en;
	logic [7:0] rd_val;

	assign reg_idx = paddr[3:2];
	assign wr_en   = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= ffcd_pkg::RST_SYNC_FIRST;
			sync_second_q <= ffcd_pkg::RST_SYNC_SECOND;
			payload_len_q <= ffcd_pkg::RST_PAYLOAD_LEN;
			bad_limit_q   <= ffcd_pkg::RST_BAD_LIMIT;
		end else if (wr_en) begin
			case (reg_idx)
				ffcd_pkg::REG_SYNC_FIRST:  sync_first_q  <= pwdata[7:0];
				ffcd_pkg::REG_SYNC_SECOND: sync_second_q <= pwdata[7:0];
				ffcd_pkg::REG_PAYLOAD_LEN: payload_len_q <= pwdata[7:0];
				ffcd_pkg::REG_BAD_LIMIT:   bad_limit_q   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			ffcd_pkg::REG_SYNC_FIRST:  rd_val = sync_first_q;
			ffcd_pkg::REG_SYNC_SECOND: rd_val = sync_second_q;
			ffcd_pkg::REG_PAYLOAD_LEN: rd_val = payload_len_q;
			ffcd_pkg::REG_BAD_LIMIT:   rd_val = bad_limit_q;
			default:                   rd_val = '0;
		endcase
	end

	assign prdata = {{(ffcd_pkg::DATA_W-8){1'b0}}, rd_val};

	// Clamp the payload length to one..MAX_PAYLOAD_LEN
	always_comb begin
		cfg.sync_first  = sync_first_q;
		cfg.sync_second = sync_second_q;
		cfg.bad_limit   = bad_limit_q;
		if (payload_len_q == 8'd0) begin
			cfg.eff_len = 8'd1;
		end else if (payload_len_q > 8'(ffcd_pkg::MAX_PAYLOAD_LEN)) begin
			cfg.eff_len = 8'(ffcd_pkg::MAX_PAYLOAD_LEN);
		end else begin
			cfg.eff_len = payload_len_q;
		end
	end

endmodule

// ----- src/ffcd_core.sv -----
// Frame sync, payload sum, checksum compare and counters, with input and result registers.
module ffcd_core (
	input  logic           clk,
	input  logic           arst_n,
	input  ffcd_pkg::cfg_t cfg,
	ffcd_rx_if.sink        rx,
	ffcd_res_if.source     result
);

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_PAYLOAD,
		PH_CHECK
	} phase_t;

	logic        in_valid_s1;
	logic [7:0]  in_byte_s1;
	logic        advance;

	phase_t      phase_q, phase_n;
	logic [7:0]  prev_q, prev_n;
	logic [7:0]  count_q, count_n;
	logic [7:0]  sum_q, sum_n;
	logic [31:0] good_q, good_n;
	logic [31:0] bad_q, bad_n;
	logic [7:0]  run_q, run_n;

	logic        pv, done, good, rec;
	logic [7:0]  pb;
	logic [6:0]  pi;

	logic        out_valid_s2;
	logic        pv_s2, done_s2, good_s2, rec_s2;
	logic [7:0]  pb_s2;
	logic [6:0]  pi_s2;

	assign advance  = in_valid_s1 & (~out_valid_s2 | result.ready);
	assign rx.ready = ~in_valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			in_byte_s1  <= '0;
		end else if (rx.ready) begin
			in_valid_s1 <= rx.valid;
			in_byte_s1  <= rx.rx_byte;
		end
	end

	always_comb begin
		phase_n = phase_q;
		prev_n  = in_byte_s1;
		count_n = count_q;
		sum_n   = sum_q;
		good_n  = good_q;
		bad_n   = bad_q;
		run_n   = run_q;
		pv      = 1'b0;
		pb      = '0;
		pi      = '0;
		done    = 1'b0;
		good    = 1'b0;
		case (phase_q)
			PH_PAYLOAD: begin
				pv      = 1'b1;
				pb      = in_byte_s1;
				pi      = count_q[6:0];
				sum_n   = sum_q + in_byte_s1;
				count_n = count_q + 8'd1;
				if (count_n >= cfg.eff_len) begin
					phase_n = PH_CHECK;
				end
			end
			PH_CHECK: begin
				done = 1'b1;
				if (sum_q == in_byte_s1) begin
					good = 1'b1;
					if (good_q != ffcd_pkg::TOTAL_MAX) begin
						good_n = good_q + 32'd1;
					end
					run_n = '0;
				end else begin
					if (bad_q != ffcd_pkg::TOTAL_MAX) begin
						bad_n = bad_q + 32'd1;
					end
					if (run_q != ffcd_pkg::RUN_MAX) begin
						run_n = run_q + 8'd1;
					end
				end
				count_n = '0;
				sum_n   = '0;
				prev_n  = '0;
				phase_n = PH_HUNT;
			end
			default: begin
				phase_n = PH_HUNT;
				if (prev_q == cfg.sync_first && in_byte_s1 == cfg.sync_second) begin
					count_n = '0;
					sum_n   = '0;
					phase_n = PH_PAYLOAD;
				end
			end
		endcase
		rec = done & (run_n <= cfg.bad_limit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			prev_q       <= '0;
			count_q      <= '0;
			sum_q        <= '0;
			good_q       <= '0;
			bad_q        <= '0;
			run_q        <= '0;
			out_valid_s2 <= 1'b0;
			pv_s2        <= 1'b0;
			pb_s2        <= '0;
			pi_s2        <= '0;
			done_s2      <= 1'b0;
			good_s2      <= 1'b0;
			rec_s2       <= 1'b0;
		end else if (advance) begin
			phase_q      <= phase_n;
			prev_q       <= prev_n;
			count_q      <= count_n;
			sum_q        <= sum_n;
			good_q       <= good_n;
			bad_q        <= bad_n;
			run_q        <= run_n;
			out_valid_s2 <= 1'b1;
			pv_s2        <= pv;
			pb_s2        <= pb;
			pi_s2        <= pi;
			done_s2      <= done;
			good_s2      <= good;
			rec_s2       <= rec;
		end else if (result.ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	// Counters beside the result register are the state left by that transfer
	assign result.valid         = out_valid_s2;
	assign result.payload_valid = pv_s2;
	assign result.payload_byte  = pb_s2;
	assign result.payload_index = pi_s2;
	assign result.frame_done    = done_s2;
	assign result.frame_good    = good_s2;
	assign result.record_enable = rec_s2;
	assign result.bad_run_count = run_q;
	assign result.good_frames   = good_q;
	assign result.bad_frames    = bad_q;

endmodule

// ----- dv/ffcd_frame_checker.sv -----
// Checker for the deframer: snoops configuration writes and both channels, predicts and compares.
module ffcd_frame_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	ffcd_rx_if                          rx,
	ffcd_res_if                         result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ffcd_pkg::ADDR_W-1:0] paddr,
	input  logic [ffcd_pkg::DATA_W-1:0] pwdata,
	input  logic                        pready,
	output int                          errors,
	output int                          pending
);
	import ffcd_pkg::*;

	typedef enum logic [1:0] {HUNTING, IN_PAYLOAD, AWAIT_SUM} frame_phase_e;

	typedef struct packed {
		logic        payload_valid;
		logic [7:0]  payload_byte;
		logic [6:0]  payload_index;
		logic        frame_done;
		logic        frame_good;
		logic        record_enable;
		logic [7:0]  bad_run_count;
		logic [31:0] good_frames;
		logic [31:0] bad_frames;
	} byte_outcome_t;

	logic [7:0]   sync_first;
	logic [7:0]   sync_second;
	logic [7:0]   len_raw;
	logic [7:0]   bad_limit;

	logic [7:0]   last_byte;
	frame_phase_e phase;
	logic [7:0]   count;
	logic [7:0]   sum;
	logic [31:0]  good_total;
	logic [31:0]  bad_total;
	logic [7:0]   bad_run;

	byte_outcome_t outcome_q[$];

	task automatic deframe(input logic [7:0] b);
		byte_outcome_t o;
		logic [7:0]    nxt;
		logic [7:0]    eff;
		o = '0;
		nxt = b;
		eff = (len_raw == 8'd0) ? 8'd1 :
			(len_raw > 8'(MAX_PAYLOAD_LEN)) ? 8'(MAX_PAYLOAD_LEN) : len_raw;
		case (phase)
			IN_PAYLOAD: begin
				o.payload_valid = 1'b1;
				o.payload_byte = b;
				o.payload_index = count[6:0];
				sum = sum + b;
				count = count + 8'd1;
				if (count >= eff)
					phase = AWAIT_SUM;
			end
			AWAIT_SUM: begin
				o.frame_done = 1'b1;
				if (sum == b) begin
					o.frame_good = 1'b1;
					if (good_total != TOTAL_MAX)
						good_total = good_total + 32'd1;
					bad_run = 8'd0;
				end else begin
					if (bad_total != TOTAL_MAX)
						bad_total = bad_total + 32'd1;
					if (bad_run != RUN_MAX)
						bad_run = bad_run + 8'd1;
				end
				o.record_enable = (bad_run <= bad_limit);
				count = 8'd0;
				sum = 8'd0;
				nxt = 8'd0;
				phase = HUNTING;
			end
			default: begin
				phase = HUNTING;
				if (last_byte == sync_first && b == sync_second) begin
					count = 8'd0;
					sum = 8'd0;
					phase = IN_PAYLOAD;
				end
			end
		endcase
		last_byte = nxt;
		o.bad_run_count = bad_run;
		o.good_frames = good_total;
		o.bad_frames = bad_total;
		outcome_q.push_back(o);
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		byte_outcome_t want;
		if (!arst_n) begin
			sync_first = RST_SYNC_FIRST;
			sync_second = RST_SYNC_SECOND;
			len_raw = RST_PAYLOAD_LEN;
			bad_limit = RST_BAD_LIMIT;
			last_byte = 8'd0;
			phase = HUNTING;
			count = 8'd0;
			sum = 8'd0;
			good_total = 32'd0;
			bad_total = 32'd0;
			bad_run = 8'd0;
			outcome_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_SYNC_FIRST:  sync_first = pwdata[7:0];
					REG_SYNC_SECOND: sync_second = pwdata[7:0];
					REG_PAYLOAD_LEN: len_raw = pwdata[7:0];
					REG_BAD_LIMIT:   bad_limit = pwdata[7:0];
					default: ;
				endcase
			end
			if (result.valid && result.ready) begin
				if (outcome_q.size() == 0) begin
					$display("%0t: result transfer with nothing expected", $time);
					errors++;
				end else begin
					want = outcome_q.pop_front();
					check_field("payload_valid", 32'(want.payload_valid), 32'(result.payload_valid));
					check_field("payload_byte", 32'(want.payload_byte), 32'(result.payload_byte));
					check_field("payload_index", 32'(want.payload_index), 32'(result.payload_index));
					check_field("frame_done", 32'(want.frame_done), 32'(result.frame_done));
					check_field("frame_good", 32'(want.frame_good), 32'(result.frame_good));
					check_field("record_enable", 32'(want.record_enable), 32'(result.record_enable));
					check_field("bad_run_count", 32'(want.bad_run_count), 32'(result.bad_run_count));
					check_field("good_frames", want.good_frames, result.good_frames);
					check_field("bad_frames", want.bad_frames, result.bad_frames);
				end
			end
			if (rx.valid && rx.ready)
				deframe(rx.rx_byte);
			pending = outcome_q.size();
		end
	end

endmodule

// ----- dv/tb_fixed_frame_checksum_deframer_core.sv -----
// Testbench top for the deframer: clock, reset, byte and configuration stimulus, verdict.
module tb_fixed_frame_checksum_deframer_core;
	import ffcd_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int HOLD_CYCLES = 200;
	localparam logic [7:0] DIRECTED_BYTES [14] = '{
		8'hFF, 8'hFF, 8'hFF,
		8'hFF, 8'h00, 8'h01,
		8'h00, 8'hFF, 8'h80, 8'h80,
		8'h55, 8'hAA, 8'h7F, 8'h00
	};

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	int         mismatch_count;
	int         pending_count;
	int         idle_cycles = 0;
	int         rx_gap_max;
	int         res_stall_max;
	bit         hold_req;
	logic [7:0] cur_first;
	logic [7:0] cur_second;
	int         cur_len;

	ffcd_rx_if  rx ();
	ffcd_res_if result ();

	fixed_frame_checksum_deframer_core i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	ffcd_frame_checker i_frame_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.pready  (pready),
		.errors  (mismatch_count),
		.pending (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((rx.valid && rx.ready) || (result.valid && result.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic push_byte(input logic [7:0] b);
		int gap;
		gap = $urandom_range(0, rx_gap_max);
		if (gap > 0) begin
			rx.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx.valid <= 1'b1;
		rx.rx_byte <= b;
		do @(posedge clk); while (!rx.ready);
	endtask

	task automatic send_frame(input bit corrupt);
		logic [7:0] frame_sum;
		logic [7:0] b;
		frame_sum = 8'd0;
		push_byte(cur_first);
		push_byte(cur_second);
		for (int k = 0; k < cur_len; k++) begin
			b = 8'($urandom);
			push_byte(b);
			frame_sum = frame_sum + b;
		end
		push_byte(corrupt ? frame_sum ^ 8'($urandom_range(1, 255)) : frame_sum);
	endtask

	task automatic send_shaped_frame(input int bad_pct);
		int shape;
		bit corrupt;
		rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
		res_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
		shape = $urandom_range(0, 9);
		corrupt = ($urandom_range(0, 99) < bad_pct);
		if (shape == 0) begin
			repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
		end else if (shape == 1) begin
			push_byte(cur_first);
			push_byte(8'($urandom));
		end else if (shape == 2) begin
			push_byte(cur_first);
		end
		send_frame(corrupt);
	endtask

	task automatic drain();
		rx.valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= DATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic reconfigure(input logic [7:0] first, input logic [7:0] second,
			input logic [7:0] len, input logic [7:0] limit);
		drain();
		write_reg(REG_SYNC_FIRST, first);
		write_reg(REG_SYNC_SECOND, second);
		write_reg(REG_PAYLOAD_LEN, len);
		write_reg(REG_BAD_LIMIT, limit);
		cur_first = first;
		cur_second = second;
		cur_len = (len == 8'd0) ? 1 : (int'(len) > MAX_PAYLOAD_LEN) ? MAX_PAYLOAD_LEN : int'(len);
	endtask

	initial begin : receiver
		int stall;
		result.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = hold_req ? HOLD_CYCLES : $urandom_range(0, res_stall_max);
			hold_req = 1'b0;
			if (stall > 0) begin
				result.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result.ready <= 1'b1;
			do @(posedge clk); while (!result.valid);
		end
	end

	initial begin : stimulus
		logic [7:0] first;
		arst_n <= 1'b0;
		rx.valid <= 1'b0;
		rx.rx_byte <= 8'd0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		hold_req = 1'b0;
		rx_gap_max = 9;
		res_stall_max = 9;
		cur_first = RST_SYNC_FIRST;
		cur_second = RST_SYNC_SECOND;
		cur_len = int'(RST_PAYLOAD_LEN);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		repeat (2) send_shaped_frame(40);

		// zero first header byte lets a cleared previous byte open a frame
		reconfigure(8'h00, 8'hFF, 8'd0, 8'd0);
		foreach (DIRECTED_BYTES[i]) push_byte(DIRECTED_BYTES[i]);

		// longest payload while the result side holds off
		reconfigure(8'h7E, 8'h7E, 8'd128, 8'd255);
		rx_gap_max = 0;
		hold_req = 1'b1;
		send_frame(1'b0);
		send_shaped_frame(50);

		reconfigure(8'hFF, 8'h00, 8'd255, 8'd1);
		send_shaped_frame(50);

		// drive the bad run counter into saturation, then clear it
		first = 8'($urandom);
		reconfigure(first, ~first, 8'd1, 8'd200);
		repeat (262) send_shaped_frame(100);
		send_shaped_frame(0);
		send_shaped_frame(100);

		repeat (4) begin
			reconfigure(8'($urandom), 8'($urandom), 8'($urandom_range(1, 12)),
				8'($urandom_range(0, 6)));
			repeat (8) send_shaped_frame(35);
		end

		drain();
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
